/* hw/rtl/msbuf_pkg.sv */
// Package for the multi-stack shared buffer: field widths, status and
// command codes, and the default sizes of the shared slot store.
// No dependencies.
`default_nettype none

package msbuf_pkg;

  // Default sizes.
  localparam int unsigned NUM_STACKS_DEF = 8;
  localparam int unsigned SLOTS_DEF      = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed field widths of the channels.
  localparam int unsigned CMD_W    = 1;
  localparam int unsigned SID_IN_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // Operation codes.
  localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
  localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage : msbuf_pkg

`default_nettype wire

/* hw/rtl/multi_stack_shared_buffer_unit.sv */
// Top level of the multi-stack shared buffer: several LIFO stacks share one
// slot store whose free slots are chained into a free list.
// Depends on msbuf_pkg.
// Requests do not overlap: one is accepted only when idle, then executed, and
// execute waits while the previous result is not taken. The link memory is read
// in the accept cycle and written back when execute finishes.
// Reset: synchronous, active low. After reset a clearing pass chains every slot
// into the free list; no request is accepted then.
`default_nettype none

module multi_stack_shared_buffer_unit #(
  parameter int unsigned NUM_STACKS = msbuf_pkg::NUM_STACKS_DEF,
  parameter int unsigned SLOTS      = msbuf_pkg::SLOTS_DEF,
  parameter int unsigned DATA_WIDTH = msbuf_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [msbuf_pkg::VALUE_W-1:0]     in_tdata,  // [31:0] push_value
  input  wire logic [3:0]                        in_tuser,  // [0] cmd, [3:1] stack_id
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [msbuf_pkg::VALUE_W-1:0]          out_tdata, // [31:0] pop_value
  output logic [msbuf_pkg::STATUS_W-1:0]         out_tuser  // [1:0] status
);

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned LINK_W = $clog2(SLOTS + 1);
  localparam int unsigned SID_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int unsigned CMP_W  = (SID_W > msbuf_pkg::SID_IN_W) ? SID_W + 1
                                                                  : msbuf_pkg::SID_IN_W + 1;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  // Slot store: data and link memories with a registered read.
  logic [DATA_WIDTH-1:0] data_mem [SLOTS];
  logic [LINK_W-1:0]     link_mem [SLOTS];
  logic [DATA_WIDTH-1:0] data_rd_r;
  logic [LINK_W-1:0]     link_rd_r;

  logic [1:0]                      state_r, state_nxt;
  logic [IDX_W-1:0]                clr_idx_r;
  logic [LINK_W-1:0]               free_head_r;
  logic [LINK_W-1:0]               top_r [NUM_STACKS];

  logic [msbuf_pkg::CMD_W-1:0]     cmd_r;
  logic [SID_W-1:0]                sid_r;
  logic                            sid_ok_r;
  logic [IDX_W-1:0]                slot_r;
  logic                            slot_null_r;
  logic [msbuf_pkg::VALUE_W-1:0]   val_r;

  logic                            out_valid_r;
  logic [msbuf_pkg::VALUE_W-1:0]   out_data_r;
  logic [msbuf_pkg::STATUS_W-1:0]  out_status_r;

  logic                            accept;
  logic                            finish;
  logic                            fail;
  logic [msbuf_pkg::CMD_W-1:0]     in_cmd;
  logic [msbuf_pkg::SID_IN_W-1:0]  in_sid;
  logic                            in_sid_ok;
  logic [SID_W-1:0]                in_sid_idx;
  logic [LINK_W-1:0]               slot_sel;
  logic                            slot_sel_null;
  logic [IDX_W-1:0]                rd_addr;
  logic                            link_we;
  logic [IDX_W-1:0]                link_wa;
  logic [LINK_W-1:0]               link_wd;
  logic                            data_we;
  logic signed [DATA_WIDTH-1:0]    data_signed;

  assign in_cmd     = in_tuser[0];
  assign in_sid     = in_tuser[3:1];
  assign in_sid_ok  = CMP_W'(in_sid) < CMP_W'(NUM_STACKS);
  assign in_sid_idx = SID_W'(in_sid);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign finish    = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign fail      = !sid_ok_r || slot_null_r;

  // A push takes the free-list head, a pop takes the stack's top.
  always_comb begin
    if (in_cmd == msbuf_pkg::CMD_PUSH) begin
      slot_sel = free_head_r;
    end else begin
      slot_sel = in_sid_ok ? top_r[in_sid_idx] : NULL_LINK;
    end
    slot_sel_null = (slot_sel == NULL_LINK);
    rd_addr       = slot_sel_null ? '0 : slot_sel[IDX_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_idx_r == LAST_IDX) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  if (finish) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Single write port of the link memory, shared by the clearing pass.
  always_comb begin
    link_we = 1'b0;
    link_wa = slot_r;
    link_wd = free_head_r;
    data_we = 1'b0;
    if (state_r == S_CLEAR) begin
      link_we = 1'b1;
      link_wa = clr_idx_r;
      link_wd = LINK_W'(clr_idx_r) + LINK_W'(1);
    end else if (finish && !fail) begin
      link_we = 1'b1;
      if (cmd_r == msbuf_pkg::CMD_PUSH) begin
        link_wd = top_r[sid_r];
        data_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (data_we) begin
      data_mem[slot_r] <= DATA_WIDTH'(val_r);
    end
    if (accept) begin
      link_rd_r <= link_mem[rd_addr];
      data_rd_r <= data_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_cmd;
      sid_r       <= in_sid_idx;
      sid_ok_r    <= in_sid_ok;
      slot_r      <= rd_addr;
      slot_null_r <= slot_sel_null;
      val_r       <= in_tdata;
    end
  end

  assign data_signed = data_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        top_r[i] <= NULL_LINK;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
      if (finish) begin
        out_valid_r <= 1'b1;
        if (!fail) begin
          if (cmd_r == msbuf_pkg::CMD_PUSH) begin
            top_r[sid_r] <= LINK_W'(slot_r);
            free_head_r  <= link_rd_r;
          end else begin
            top_r[sid_r] <= link_rd_r;
            free_head_r  <= LINK_W'(slot_r);
          end
        end
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (fail) begin
        out_status_r <= (cmd_r == msbuf_pkg::CMD_PUSH) ? msbuf_pkg::ST_OVERFLOW
                                                        : msbuf_pkg::ST_UNDERFLOW;
        out_data_r   <= '0;
      end else begin
        out_status_r <= msbuf_pkg::ST_OK;
        out_data_r   <= (cmd_r == msbuf_pkg::CMD_POP)
                        ? msbuf_pkg::VALUE_W'(data_signed) : '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  a_failed_request_returns_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != msbuf_pkg::ST_OK) |-> (out_tdata == '0))
    else $error("failed request carries nonzero data");

  a_accept_enters_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC) && !in_tready)
    else $error("accepted request did not enter execute");

  a_free_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= NULL_LINK)
    else $error("free-list head out of range");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_tvalid)
    else $error("execute step produced no result");
`endif

endmodule : multi_stack_shared_buffer_unit

`default_nettype wire

/* test/multi_stack_shared_buffer_unit_test.sv */
// Testbench for multi_stack_shared_buffer_unit: push and pop requests on the
// shared stack store, checked against a built-in model of stacks and free list.
// Depends on msbuf_pkg and the multi_stack_shared_buffer_unit RTL.
`timescale 1ns / 1ps

module multi_stack_shared_buffer_unit_test;

  localparam int unsigned NUM_STACKS = msbuf_pkg::NUM_STACKS_DEF;
  localparam int unsigned SLOTS      = msbuf_pkg::SLOTS_DEF;
  localparam int unsigned DATA_WIDTH = msbuf_pkg::DATA_WIDTH_DEF;
  localparam int unsigned VALUE_W    = msbuf_pkg::VALUE_W;
  localparam int unsigned STATUS_W   = msbuf_pkg::STATUS_W;
  localparam int unsigned CMD_W      = msbuf_pkg::CMD_W;
  localparam int unsigned LINK_W     = $clog2(SLOTS + 1);
  localparam int unsigned SID_W      = msbuf_pkg::SID_IN_W;
  localparam logic [LINK_W-1:0] NIL  = LINK_W'(SLOTS);
  localparam logic [VALUE_W-1:0] DATA_MASK =
    (DATA_WIDTH >= VALUE_W) ? '1 : VALUE_W'((64'd1 << DATA_WIDTH) - 64'd1);
  localparam int unsigned RESULT_LATENCY = 2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
  } outcome_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [VALUE_W-1:0]   in_tdata   = '0;
  logic [3:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [VALUE_W-1:0]   out_tdata;
  logic [STATUS_W-1:0]  out_tuser;

  // Model of the shared store.
  logic [VALUE_W-1:0] mem_value [SLOTS];
  logic [LINK_W-1:0]  mem_next  [SLOTS];
  logic [LINK_W-1:0]  top_of    [NUM_STACKS];
  logic [LINK_W-1:0]  free_ptr;
  int unsigned        depth     [NUM_STACKS];
  int unsigned        slots_used;

  outcome_t    pending_results [$];
  int unsigned errors = 0;
  bit          steady = 1'b0;
  int unsigned ready_hold = 0;

  multi_stack_shared_buffer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none in a steady stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SID_W-1:0] pick_sid();
    return SID_W'($urandom_range(0, 7));
  endfunction

  // Applies one request to the model and returns the result it must produce.
  function automatic outcome_t apply_request(input logic [CMD_W-1:0] cmd,
                                             input logic [SID_W-1:0] sid,
                                             input logic [VALUE_W-1:0] value);
    outcome_t    res;
    logic [LINK_W-1:0] slot;
    res.status = msbuf_pkg::ST_OK;
    res.value  = '0;
    if (cmd == msbuf_pkg::CMD_PUSH) begin
      if (sid >= NUM_STACKS || free_ptr >= NIL) begin
        res.status = msbuf_pkg::ST_OVERFLOW;
      end else begin
        slot = free_ptr;
        free_ptr = (mem_next[slot] < NIL) ? mem_next[slot] : NIL;
        mem_next[slot] = top_of[sid];
        top_of[sid] = slot;
        mem_value[slot] = value & DATA_MASK;
        depth[sid]++;
        slots_used++;
      end
    end else begin
      if (sid >= NUM_STACKS || top_of[sid] >= NIL) begin
        res.status = msbuf_pkg::ST_UNDERFLOW;
      end else begin
        slot = top_of[sid];
        res.value = mem_value[slot] & DATA_MASK;
        if (DATA_WIDTH < VALUE_W && res.value[DATA_WIDTH-1]) res.value |= ~DATA_MASK;
        top_of[sid] = (mem_next[slot] < NIL) ? mem_next[slot] : NIL;
        mem_next[slot] = free_ptr;
        free_ptr = slot;
        depth[sid]--;
        slots_used--;
      end
    end
    return res;
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [SID_W-1:0] sid,
                              input logic [VALUE_W-1:0] value);
    int unsigned gap;
    outcome_t    want_res;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= {sid, cmd};
    do @(posedge clk); while (!in_tready);
    want_res = apply_request(cmd, sid, value);
    pending_results = {pending_results, want_res};
  endtask

  // Holds the input off until every outstanding result has come back.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_basic_stacks();
    send_request(msbuf_pkg::CMD_POP, 3'd0, $urandom);
    send_request(msbuf_pkg::CMD_POP, 3'd7, $urandom);
    send_request(msbuf_pkg::CMD_PUSH, 3'd0, 32'h7fff_ffff);
    send_request(msbuf_pkg::CMD_PUSH, 3'd7, 32'h8000_0000);
    send_request(msbuf_pkg::CMD_PUSH, 3'd3, 32'h0000_0000);
    send_request(msbuf_pkg::CMD_PUSH, 3'd3, 32'hffff_ffff);
    send_request(msbuf_pkg::CMD_PUSH, 3'd5, 32'h5555_5555);
    send_request(msbuf_pkg::CMD_PUSH, 3'd2, 32'haaaa_aaaa);
    // Stack 3 comes back in reverse order, then reports underflow.
    send_request(msbuf_pkg::CMD_POP, 3'd3, $urandom);
    send_request(msbuf_pkg::CMD_POP, 3'd3, $urandom);
    send_request(msbuf_pkg::CMD_POP, 3'd3, $urandom);
    send_request(msbuf_pkg::CMD_POP, 3'd0, $urandom);
    send_request(msbuf_pkg::CMD_POP, 3'd7, $urandom);
    send_request(msbuf_pkg::CMD_POP, 3'd2, $urandom);
    send_request(msbuf_pkg::CMD_POP, 3'd5, $urandom);
    wait_for_results();
  endtask

  task automatic test_store_full();
    logic [SID_W-1:0] sid;
    while (slots_used < SLOTS) send_request(msbuf_pkg::CMD_PUSH, pick_sid(), pick_value());
    repeat (3) send_request(msbuf_pkg::CMD_PUSH, pick_sid(), pick_value());
    // A slot freed by a pop must be handed out again at once.
    do sid = pick_sid(); while (depth[sid] == 0);
    send_request(msbuf_pkg::CMD_POP, sid, $urandom);
    send_request(msbuf_pkg::CMD_PUSH, pick_sid(), pick_value());
    send_request(msbuf_pkg::CMD_PUSH, pick_sid(), pick_value());
    while (slots_used != 0) begin
      do sid = pick_sid(); while (depth[sid] == 0);
      send_request(msbuf_pkg::CMD_POP, sid, $urandom);
    end
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int unsigned push_pct [8] = '{85, 50, 20, 65, 35, 90, 10, 50};
    logic [SID_W-1:0] hot_sid;
    logic [SID_W-1:0] sid;
    bit hot;
    for (int phase = 0; phase < 8; phase++) begin
      steady  = (phase == 3);
      hot     = $urandom_range(0, 2) == 0;
      hot_sid = pick_sid();
      for (int n = 0; n < 30; n++) begin
        sid = hot ? (hot_sid ^ SID_W'($urandom_range(0, 1))) : pick_sid();
        if ($urandom_range(0, 99) < push_pct[phase])
          send_request(msbuf_pkg::CMD_PUSH, sid, pick_value());
        else
          send_request(msbuf_pkg::CMD_POP, sid, $urandom);
      end
      if (phase == 4) wait_for_results();
    end
    steady = 1'b0;
    wait_for_results();
  endtask

  always @(posedge clk) begin
    if (steady) begin
      out_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
      ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin : check_result
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending: status %0d pop_value %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          errors++;
        end
        if (out_tdata !== want.value) begin
          $display("%0t: pop_value expected %h actual %h", $time, want.value, out_tdata);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      mem_value[i] = '0;
      mem_next[i]  = (i == SLOTS - 1) ? NIL : LINK_W'(i + 1);
    end
    for (int s = 0; s < NUM_STACKS; s++) begin
      top_of[s] = NIL;
      depth[s]  = 0;
    end
    free_ptr   = '0;
    slots_used = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_stacks();
    test_store_full();
    test_random_traffic();

    repeat (RESULT_LATENCY + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/msbuf_pkg.sv
hw/rtl/multi_stack_shared_buffer_unit.sv
test/multi_stack_shared_buffer_unit_test.sv
